@@ sv/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared beat types, the group hand-off type and the pad character constant.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Pad character '=' of the base64 alphabet.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Input beat: one encoded character and the end-of-string flag.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_beat_t;

  // Output beat: one decoded byte and the last-of-step flag.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_byte;
  } out_beat_t;

  // A finished group: 24 bits with the first byte on top, and the number
  // of bytes (1 to 3) to be sent from it.
  typedef struct packed {
    logic [23:0] value;
    logic [1:0]  count;
  } grp_t;

endpackage

@@ sv/b64d_group.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder group assembler
// Registers the incoming character, maps it to a sextet and builds groups.
// ----------------------------------------------------------------------------
module b64d_group (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64d_pkg::in_beat_t  in_data,
  output logic                grp_valid,
  input  logic                grp_ready,
  output b64d_pkg::grp_t      grp
);

  logic                in_v_r, in_v_nxt;
  b64d_pkg::in_beat_t  in_d_r;
  logic [17:0]         acc_r, acc_nxt;
  logic [1:0]          pos_r, pos_nxt;
  logic                pad3_r, pad3_nxt;

  logic [5:0]  sextet;
  logic [23:0] acc24;
  logic        pad3;
  logic        pad4;
  logic        complete;
  logic        adv;
  logic        is_pad;

  // Permissive character map; only the low six bits are kept.
  always_comb begin
    if (in_d_r.char_in >= 8'h61) begin
      sextet = 6'(in_d_r.char_in - 8'h61 + 8'd26);
    end else if (in_d_r.char_in >= 8'h41) begin
      sextet = 6'(in_d_r.char_in - 8'h41);
    end else if (in_d_r.char_in >= 8'h30) begin
      sextet = 6'(in_d_r.char_in + 8'd4);
    end else if (in_d_r.char_in == 8'h2B) begin
      sextet = 6'd62;
    end else if (in_d_r.char_in == 8'h2F) begin
      sextet = 6'd63;
    end else begin
      sextet = 6'd0;
    end
  end

  assign is_pad   = (in_d_r.char_in == b64d_pkg::PAD_CHAR);
  assign acc24    = {acc_r, sextet};
  assign pad3     = (pos_r == 2'd2) ? is_pad : pad3_r;
  assign pad4     = (pos_r == 2'd3) && is_pad;
  assign complete = (pos_r == 2'd3) || in_d_r.last_char;

  assign grp_valid = in_v_r && complete;
  assign adv       = in_v_r && (!complete || grp_ready);
  assign in_ready  = !in_v_r || adv;

  // A short group is filled with zero sextets.
  always_comb begin
    case (pos_r)
      2'd0:    grp.value = {acc24[5:0], 18'd0};
      2'd1:    grp.value = {acc24[11:0], 12'd0};
      2'd2:    grp.value = {acc24[17:0], 6'd0};
      default: grp.value = acc24;
    endcase
    if (pad3) begin
      grp.count = 2'd1;
    end else if (pad4) begin
      grp.count = 2'd2;
    end else begin
      grp.count = 2'd3;
    end
  end

  always_comb begin
    in_v_nxt = adv ? 1'b0 : in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    pad3_nxt = pad3_r;
    if (adv) begin
      if (complete) begin
        acc_nxt  = '0;
        pos_nxt  = '0;
        pad3_nxt = 1'b0;
      end else begin
        acc_nxt  = acc24[17:0];
        pos_nxt  = pos_r + 2'd1;
        pad3_nxt = pad3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      acc_r  <= '0;
      pos_r  <= '0;
      pad3_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      pad3_r <= pad3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_d_r <= in_data;
    end
  end

endmodule

@@ sv/b64d_obuf.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder output buffer
// Holds one decoded group and sends its bytes one beat at a time.
// ----------------------------------------------------------------------------
module b64d_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_valid,
  output logic                grp_ready,
  input  b64d_pkg::grp_t      grp,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_beat_t out_data
);

  logic [1:0]  cnt_r, cnt_nxt;
  logic [23:0] data_r, data_nxt;
  logic        pop;
  logic        load;

  assign out_valid          = (cnt_r != 2'd0);
  assign pop                = out_valid && out_ready;
  assign grp_ready          = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign load               = grp_valid && grp_ready;
  assign out_data.byte_out  = data_r[23:16];
  assign out_data.last_byte = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    if (load) begin
      cnt_nxt  = grp.count;
      data_nxt = grp.value;
    end else if (pop) begin
      cnt_nxt  = cnt_r - 2'd1;
      data_nxt = {data_r[15:0], 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ sv/base64_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder unit
// Streaming base64 text decoder, one character in and one byte out per beat.
// ----------------------------------------------------------------------------
// Usage: the in_ channel carries one ASCII character per beat, with
// last_char set on the final character of a string. The out_ channel
// carries decoded bytes; last_byte marks the final byte that one input
// character causes. Every fourth character closes a group and yields one
// to three bytes depending on '=' padding. A final character that ends a
// partial group closes it as if zero sextets followed.
// Timing: a character is taken into an input register; a group closed by
// it is then loaded into the output buffer, from which its first byte
// is sent. Throughput is one character per cycle while out_ready stays
// high, set by the three-byte output buffer draining one byte a cycle
// while the next group is assembled; a partial group closed early can
// briefly hold off input while its bytes drain.
// Reset (rst_n low, synchronous) empties both registers and clears the
// group state. When the receiver stalls, the buffer holds its bytes and
// input stops only once a second group is ready to close.
// ----------------------------------------------------------------------------
module base64_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64d_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_beat_t out_data
);

  // Hand-off of a finished group from the assembler to the buffer.
  logic           grp_valid;
  logic           grp_ready;
  b64d_pkg::grp_t grp;

  // Input register, sextet map and group accumulator.
  b64d_group u_group (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  // Result register: serializes the bytes of one group.
  b64d_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/b64d_checker.sv @@
// ----------------------------------------------------------------------------
// Base64 decoder port checker
// Port-level assertions, attached to the top level with a bind.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input b64d_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input b64d_pkg::out_beat_t out_data
);

  // A waiting input beat holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while waiting");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // The bytes of one group follow back to back.
  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_byte |=> out_valid)
    else $error("gap inside a group of bytes");

  // Reset empties the output buffer.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Reset empties the input register, so input is open.
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind base64_decoder_unit b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
